### hw/rtl/trse_pkg.sv
// ----------------------------------------------------------------------------
// trse_pkg
// Types, constants and the codeword helper for the tri-state switch encoder.
// ----------------------------------------------------------------------------
package trse_pkg;

   localparam int CODE_W             = 5;
   localparam int SYMBOLS            = 12;
   localparam int SYNC_LOW_UNITS     = 31;
   localparam int LONG_UNITS         = 3;
   localparam int PULSE_TICKS_W      = 16;
   localparam int REPEAT_COUNT_W     = 8;
   localparam int SYM_IDX_W          = 4;
   localparam int UNIT_W             = 5;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 16;
   localparam int PULSE_TICKS_RESET  = 350;
   localparam int REPEAT_COUNT_RESET = 10;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } trse_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_TICKS  = 1'b0,
      CSR_REPEAT_COUNT = 1'b1
   } trse_csr_index_type;

   typedef struct packed {
      logic              operation;
      logic [CODE_W-1:0] group_code;
      logic [CODE_W-1:0] device_code;
      logic              switch_on;
   } trse_req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
      logic finished;
   } trse_rsp_type;

   typedef struct packed {
      logic [PULSE_TICKS_W-1:0]  pulse_ticks;
      logic [REPEAT_COUNT_W-1:0] repeat_count;
   } trse_cfg_type;

   // clear switch gives F (1), set switch gives 0
   function automatic logic [SYMBOLS-1:0] make_codeword(
      input logic [CODE_W-1:0] grp,
      input logic [CODE_W-1:0] dev,
      input logic              on
   );
      make_codeword = {~grp, ~dev, ~on, on};
   endfunction

endpackage

### hw/rtl/trse_csr.sv
// ----------------------------------------------------------------------------
// trse_csr
// Configuration registers: pulse unit length and frame repeat count.
// ----------------------------------------------------------------------------
module trse_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [trse_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output trse_pkg::trse_cfg_type              cfg
);
   import trse_pkg::*;

   trse_cfg_type cfg_ff;
   trse_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (trse_csr_index_type'(csr_index))
            CSR_PULSE_TICKS: begin
               cfg_in.pulse_ticks = csr_wdata[PULSE_TICKS_W-1:0];
            end
            CSR_REPEAT_COUNT: begin
               cfg_in.repeat_count = csr_wdata[REPEAT_COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks  <= PULSE_TICKS_W'(PULSE_TICKS_RESET);
         cfg_ff.repeat_count <= REPEAT_COUNT_W'(REPEAT_COUNT_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/trse_seq.sv
// ----------------------------------------------------------------------------
// trse_seq
// Transmit sequencer: codeword, symbol, phase, unit and tick counters; one
// beat per clock, while step is held high, advances the state and forms the result.
// ----------------------------------------------------------------------------
module trse_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  trse_pkg::trse_req_type  req,
   input  trse_pkg::trse_cfg_type  cfg,
   output trse_pkg::trse_rsp_type  rsp
);
   import trse_pkg::*;

   logic [SYMBOLS-1:0]        codeword_ff,     codeword_in;
   logic [REPEAT_COUNT_W-1:0] repeats_left_ff, repeats_left_in;
   logic [SYM_IDX_W-1:0]      symbol_index_ff, symbol_index_in;
   logic                      half_symbol_ff,  half_symbol_in;
   logic                      in_sync_ff,      in_sync_in;
   logic                      high_phase_ff,   high_phase_in;
   logic [UNIT_W-1:0]         unit_count_ff,   unit_count_in;
   logic [PULSE_TICKS_W-1:0]  tick_count_ff,   tick_count_in;
   logic                      active_ff,       active_in;

   logic [PULSE_TICKS_W-1:0]  pt;
   logic [PULSE_TICKS_W-1:0]  tick_inc;
   logic [UNIT_W-1:0]         unit_inc;
   logic [UNIT_W-1:0]         units;
   logic [SYM_IDX_W-1:0]      bit_sel;
   logic [SYM_IDX_W-1:0]      sym_inc;
   logic                      is_f;

   always_comb begin
      pt       = (cfg.pulse_ticks == '0) ? PULSE_TICKS_W'(1) : cfg.pulse_ticks;
      tick_inc = tick_count_ff + PULSE_TICKS_W'(1);
      unit_inc = unit_count_ff + UNIT_W'(1);
      sym_inc  = symbol_index_ff + SYM_IDX_W'(1);
      bit_sel  = SYM_IDX_W'(SYMBOLS - 1) - symbol_index_ff;
      is_f     = (symbol_index_ff < SYM_IDX_W'(SYMBOLS)) ? codeword_ff[bit_sel] : 1'b0;
      if (in_sync_ff) begin
         units = high_phase_ff ? UNIT_W'(1) : UNIT_W'(SYNC_LOW_UNITS);
      end else if (is_f && half_symbol_ff) begin
         units = high_phase_ff ? UNIT_W'(LONG_UNITS) : UNIT_W'(1);
      end else begin
         units = high_phase_ff ? UNIT_W'(1) : UNIT_W'(LONG_UNITS);
      end
   end

   always_comb begin
      codeword_in     = codeword_ff;
      repeats_left_in = repeats_left_ff;
      symbol_index_in = symbol_index_ff;
      half_symbol_in  = half_symbol_ff;
      in_sync_in      = in_sync_ff;
      high_phase_in   = high_phase_ff;
      unit_count_in   = unit_count_ff;
      tick_count_in   = tick_count_ff;
      active_in       = active_ff;
      rsp             = '0;

      if (step) begin
         if (trse_op_type'(req.operation) == OP_START) begin
            if (!active_ff) begin
               codeword_in     = make_codeword(req.group_code, req.device_code,
                                               req.switch_on);
               repeats_left_in = (cfg.repeat_count == '0) ? REPEAT_COUNT_W'(1)
                                                          : cfg.repeat_count;
               symbol_index_in = '0;
               half_symbol_in  = 1'b0;
               in_sync_in      = 1'b0;
               high_phase_in   = 1'b1;
               unit_count_in   = '0;
               tick_count_in   = '0;
               active_in       = 1'b1;
               rsp.accepted    = 1'b1;
            end
         end else if (active_ff) begin
            rsp.line_level = high_phase_ff;
            tick_count_in  = tick_inc;
            if (tick_inc == '0 || tick_inc >= pt) begin
               tick_count_in = '0;
               unit_count_in = unit_inc;
               if (unit_inc == '0 || unit_inc >= units) begin
                  unit_count_in = '0;
                  if (high_phase_ff) begin
                     high_phase_in = 1'b0;
                  end else begin
                     high_phase_in = 1'b1;
                     if (in_sync_ff) begin
                        in_sync_in      = 1'b0;
                        symbol_index_in = '0;
                        half_symbol_in  = 1'b0;
                        repeats_left_in = repeats_left_ff - REPEAT_COUNT_W'(1);
                        if (repeats_left_in == '0) begin
                           active_in     = 1'b0;
                           high_phase_in = 1'b0;
                           rsp.finished  = 1'b1;
                        end
                     end else if (!half_symbol_ff) begin
                        half_symbol_in = 1'b1;
                     end else begin
                        half_symbol_in  = 1'b0;
                        symbol_index_in = sym_inc;
                        if (sym_inc >= SYM_IDX_W'(SYMBOLS)) begin
                           symbol_index_in = '0;
                           in_sync_in      = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end
      rsp.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codeword_ff     <= '0;
         repeats_left_ff <= '0;
         symbol_index_ff <= '0;
         half_symbol_ff  <= 1'b0;
         in_sync_ff      <= 1'b0;
         high_phase_ff   <= 1'b0;
         unit_count_ff   <= '0;
         tick_count_ff   <= '0;
         active_ff       <= 1'b0;
      end else begin
         codeword_ff     <= codeword_in;
         repeats_left_ff <= repeats_left_in;
         symbol_index_ff <= symbol_index_in;
         half_symbol_ff  <= half_symbol_in;
         in_sync_ff      <= in_sync_in;
         high_phase_ff   <= high_phase_in;
         unit_count_ff   <= unit_count_in;
         tick_count_ff   <= tick_count_in;
         active_ff       <= active_in;
      end
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (!high_phase_ff && !in_sync_ff))
      else $error("idle with phase or sync flag set");

   a_symbol_range: assert property (@(posedge clock) disable iff (reset)
      symbol_index_ff < SYM_IDX_W'(SYMBOLS))
      else $error("symbol index past codeword");

   a_sync_index: assert property (@(posedge clock) disable iff (reset)
      in_sync_ff |-> (symbol_index_ff == '0 && !half_symbol_ff))
      else $error("sync with symbol position not cleared");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      unit_count_ff < UNIT_W'(SYNC_LOW_UNITS))
      else $error("unit count past longest phase");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.finished |=> !active_ff)
      else $error("still active after finish");

endmodule

### hw/rtl/tristate_remote_switch_encoder_core.sv
// ----------------------------------------------------------------------------
// tristate_remote_switch_encoder_core
// Tri-state on-off keyed remote switch encoder with valid/ready channels.
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after the request beat
// throughput: one beat per clock while the response is taken, set by the single sequencer update
// the response register frees in the same cycle it is taken
// reset: synchronous, clears the sequencer to idle and loads
//        pulse_ticks 350 and repeat_count 10
module tristate_remote_switch_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  trse_pkg::trse_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output trse_pkg::trse_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trse_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [trse_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import trse_pkg::*;

   trse_cfg_type cfg;
   trse_rsp_type step_rsp;
   trse_rsp_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         step;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign step         = req_valid && req_ready;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   trse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   trse_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= step_rsp;
      end
   end

endmodule
